### rtl/sic_pkg.sv
package sic_pkg;

	// Width of each coordinate port
	localparam int IN_BITS = 32;

	// Coordinate differences formed in the first stage
	localparam int NUM_DIFF = 6;
	localparam int DIF_A = 0;  // e1 - s1
	localparam int DIF_B = 1;  // s2 - s1
	localparam int DIF_C = 2;  // e2 - s1
	localparam int DIF_D = 3;  // e2 - s2
	localparam int DIF_F = 4;  // s1 - s2
	localparam int DIF_G = 5;  // e1 - s2

	// Orientation cross products: u.x * v.y - u.y * v.x
	// order: s2 vs seg1, e2 vs seg1, s1 vs seg2, e1 vs seg2
	localparam int NUM_CROSS = 4;
	localparam int CR_U [NUM_CROSS] = '{DIF_A, DIF_A, DIF_D, DIF_D};
	localparam int CR_V [NUM_CROSS] = '{DIF_B, DIF_C, DIF_F, DIF_G};

	// Dot products: u.x * v.x + u.y * v.y
	localparam int NUM_DOT = 6;
	localparam int DOT_D1 = 0;  // (s2 - s1).(e1 - s1)
	localparam int DOT_D2 = 1;  // (e2 - s1).(e1 - s1)
	localparam int DOT_L1 = 2;  // |e1 - s1|^2
	localparam int DOT_D3 = 3;  // (s1 - s2).(e2 - s2)
	localparam int DOT_D4 = 4;  // (e1 - s2).(e2 - s2)
	localparam int DOT_L2 = 5;  // |e2 - s2|^2
	localparam int DT_U [NUM_DOT] = '{DIF_B, DIF_C, DIF_A, DIF_F, DIF_G, DIF_D};
	localparam int DT_V [NUM_DOT] = '{DIF_A, DIF_A, DIF_A, DIF_D, DIF_D, DIF_D};

	// Projection of each endpoint onto the other segment; same order as the crosses
	localparam int NUM_PROJ = 4;
	localparam int PJ_S2 = 0;
	localparam int PJ_E2 = 1;
	localparam int PJ_S1 = 2;
	localparam int PJ_E1 = 3;
	localparam int PJ_DOT [NUM_PROJ] = '{DOT_D1, DOT_D2, DOT_D3, DOT_D4};
	localparam int PJ_LEN [NUM_PROJ] = '{DOT_L1, DOT_L1, DOT_L2, DOT_L2};

	// Point equality flags
	typedef struct packed {
		logic pt1;    // seg1 degenerates to a point
		logic pt2;    // seg2 degenerates to a point
		logic pp_eq;  // s1 == s2
	} sic_eq_t;

	// Sign and compare flags feeding the final decision
	typedef struct packed {
		sic_eq_t             eq;
		logic [NUM_CROSS-1:0] or_neg;
		logic [NUM_CROSS-1:0] or_zero;
		logic [NUM_PROJ-1:0]  dt_neg;
		logic [NUM_PROJ-1:0]  dt_zero;
		logic [NUM_PROJ-1:0]  dt_gt;   // projection beyond squared length
		logic [NUM_PROJ-1:0]  dt_eq;   // projection equals squared length
		logic                 d1_gt_d2;
	} sic_flags_t;

	typedef enum logic [1:0] {
		REL_DISJOINT = 2'd0,
		REL_TOUCH    = 2'd1,
		REL_CROSS    = 2'd2,
		REL_OVERLAP  = 2'd3
	} sic_rel_t;

endpackage

### rtl/sic_delta.sv
module sic_delta #(
	parameter int COORD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic signed [sic_pkg::IN_BITS-1:0]  seg1_start_x,
	input  logic signed [sic_pkg::IN_BITS-1:0]  seg1_start_y,
	input  logic signed [sic_pkg::IN_BITS-1:0]  seg1_end_x,
	input  logic signed [sic_pkg::IN_BITS-1:0]  seg1_end_y,
	input  logic signed [sic_pkg::IN_BITS-1:0]  seg2_start_x,
	input  logic signed [sic_pkg::IN_BITS-1:0]  seg2_start_y,
	input  logic signed [sic_pkg::IN_BITS-1:0]  seg2_end_x,
	input  logic signed [sic_pkg::IN_BITS-1:0]  seg2_end_y,
	output logic                                vld_s1,
	output sic_pkg::sic_eq_t                    eq_s1,
	output logic signed [COORD_BITS:0]          dx_s1 [sic_pkg::NUM_DIFF],
	output logic signed [COORD_BITS:0]          dy_s1 [sic_pkg::NUM_DIFF]
);
	import sic_pkg::*;

	localparam int DW = COORD_BITS + 1;

	logic signed [DW-1:0] s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y;

	// Keep the low coordinate bits, sign-extend one bit for exact differences
	assign s1x = DW'($signed(seg1_start_x[COORD_BITS-1:0]));
	assign s1y = DW'($signed(seg1_start_y[COORD_BITS-1:0]));
	assign e1x = DW'($signed(seg1_end_x[COORD_BITS-1:0]));
	assign e1y = DW'($signed(seg1_end_y[COORD_BITS-1:0]));
	assign s2x = DW'($signed(seg2_start_x[COORD_BITS-1:0]));
	assign s2y = DW'($signed(seg2_start_y[COORD_BITS-1:0]));
	assign e2x = DW'($signed(seg2_end_x[COORD_BITS-1:0]));
	assign e2y = DW'($signed(seg2_end_y[COORD_BITS-1:0]));

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	// Stage 1: differences and point equality
	always_ff @(posedge clk) begin
		if (in_vld) begin
			eq_s1.pt1   <= (s1x == e1x) && (s1y == e1y);
			eq_s1.pt2   <= (s2x == e2x) && (s2y == e2y);
			eq_s1.pp_eq <= (s1x == s2x) && (s1y == s2y);
			dx_s1[DIF_A] <= e1x - s1x;
			dy_s1[DIF_A] <= e1y - s1y;
			dx_s1[DIF_B] <= s2x - s1x;
			dy_s1[DIF_B] <= s2y - s1y;
			dx_s1[DIF_C] <= e2x - s1x;
			dy_s1[DIF_C] <= e2y - s1y;
			dx_s1[DIF_D] <= e2x - s2x;
			dy_s1[DIF_D] <= e2y - s2y;
			dx_s1[DIF_F] <= s1x - s2x;
			dy_s1[DIF_F] <= s1y - s2y;
			dx_s1[DIF_G] <= e1x - s2x;
			dy_s1[DIF_G] <= e1y - s2y;
		end
	end

endmodule

### rtl/sic_product.sv
module sic_product #(
	parameter int COORD_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             vld_s1,
	input  sic_pkg::sic_eq_t                 eq_s1,
	input  logic signed [COORD_BITS:0]       dx_s1 [sic_pkg::NUM_DIFF],
	input  logic signed [COORD_BITS:0]       dy_s1 [sic_pkg::NUM_DIFF],
	output logic                             vld_s2,
	output sic_pkg::sic_eq_t                 eq_s2,
	output logic signed [2*COORD_BITS+1:0]   pca_s2 [sic_pkg::NUM_CROSS],
	output logic signed [2*COORD_BITS+1:0]   pcb_s2 [sic_pkg::NUM_CROSS],
	output logic signed [2*COORD_BITS+1:0]   pda_s2 [sic_pkg::NUM_DOT],
	output logic signed [2*COORD_BITS+1:0]   pdb_s2 [sic_pkg::NUM_DOT]
);
	import sic_pkg::*;

	localparam int PW = 2 * (COORD_BITS + 1);

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	// Stage 2: twenty signed multipliers, one result register each
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			eq_s2 <= eq_s1;
			for (int k = 0; k < NUM_CROSS; k++) begin
				pca_s2[k] <= PW'(dx_s1[CR_U[k]]) * PW'(dy_s1[CR_V[k]]);
				pcb_s2[k] <= PW'(dy_s1[CR_U[k]]) * PW'(dx_s1[CR_V[k]]);
			end
			for (int k = 0; k < NUM_DOT; k++) begin
				pda_s2[k] <= PW'(dx_s1[DT_U[k]]) * PW'(dx_s1[DT_V[k]]);
				pdb_s2[k] <= PW'(dy_s1[DT_U[k]]) * PW'(dy_s1[DT_V[k]]);
			end
		end
	end

endmodule

### rtl/sic_combine.sv
module sic_combine #(
	parameter int COORD_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             vld_s2,
	input  sic_pkg::sic_eq_t                 eq_s2,
	input  logic signed [2*COORD_BITS+1:0]   pca_s2 [sic_pkg::NUM_CROSS],
	input  logic signed [2*COORD_BITS+1:0]   pcb_s2 [sic_pkg::NUM_CROSS],
	input  logic signed [2*COORD_BITS+1:0]   pda_s2 [sic_pkg::NUM_DOT],
	input  logic signed [2*COORD_BITS+1:0]   pdb_s2 [sic_pkg::NUM_DOT],
	output logic                             vld_s4,
	output sic_pkg::sic_flags_t              flags_s4
);
	import sic_pkg::*;

	localparam int PW   = 2 * (COORD_BITS + 1);
	localparam int SW   = PW + 1;
	localparam int CMPW = SW + 1;

	logic                  vld_s3;
	sic_eq_t               eq_s3;
	logic signed [SW-1:0]  cr_s3 [NUM_CROSS];
	logic signed [SW-1:0]  dt_s3 [NUM_DOT];
	logic signed [CMPW-1:0] gap [NUM_PROJ];
	logic signed [CMPW-1:0] span;
	sic_flags_t            flags_d;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Stage 3: cross products and dot products
	always_ff @(posedge clk) begin
		if (vld_s2) begin
			eq_s3 <= eq_s2;
			for (int k = 0; k < NUM_CROSS; k++) begin
				cr_s3[k] <= SW'(pca_s2[k]) - SW'(pcb_s2[k]);
			end
			for (int k = 0; k < NUM_DOT; k++) begin
				dt_s3[k] <= SW'(pda_s2[k]) + SW'(pdb_s2[k]);
			end
		end
	end

	// Projection minus squared length, and first minus second projection on seg1
	always_comb begin
		for (int p = 0; p < NUM_PROJ; p++) begin
			gap[p] = CMPW'(dt_s3[PJ_DOT[p]]) - CMPW'(dt_s3[PJ_LEN[p]]);
		end
		span = CMPW'(dt_s3[DOT_D1]) - CMPW'(dt_s3[DOT_D2]);
	end

	// Signs and compare results
	always_comb begin
		flags_d.eq = eq_s3;
		for (int k = 0; k < NUM_CROSS; k++) begin
			flags_d.or_neg[k]  = cr_s3[k][SW-1];
			flags_d.or_zero[k] = (cr_s3[k] == '0);
		end
		for (int p = 0; p < NUM_PROJ; p++) begin
			flags_d.dt_neg[p]  = dt_s3[PJ_DOT[p]][SW-1];
			flags_d.dt_zero[p] = (dt_s3[PJ_DOT[p]] == '0);
			flags_d.dt_gt[p]   = !gap[p][CMPW-1] && (gap[p] != '0);
			flags_d.dt_eq[p]   = (gap[p] == '0);
		end
		flags_d.d1_gt_d2 = !span[CMPW-1] && (span != '0);
	end

	// Stage 4 register
	always_ff @(posedge clk) begin
		if (vld_s3) begin
			flags_s4 <= flags_d;
		end
	end

endmodule

### rtl/segment_intersection_classifier_unit.sv
// Segment pair classifier: one pair accepted per cycle, busy is never raised.
// Five register stages run from start to done:
// differences, 33x33 multipliers, sums, wide compares, final decision.
// No flow control on the result side: done is a one-cycle strobe.
// Asynchronous active-low reset clears the valid bits only; no other state.
module segment_intersection_classifier_unit #(
	parameter int COORD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [sic_pkg::IN_BITS-1:0]  seg1_start_x,
	input  logic signed [sic_pkg::IN_BITS-1:0]  seg1_start_y,
	input  logic signed [sic_pkg::IN_BITS-1:0]  seg1_end_x,
	input  logic signed [sic_pkg::IN_BITS-1:0]  seg1_end_y,
	input  logic signed [sic_pkg::IN_BITS-1:0]  seg2_start_x,
	input  logic signed [sic_pkg::IN_BITS-1:0]  seg2_start_y,
	input  logic signed [sic_pkg::IN_BITS-1:0]  seg2_end_x,
	input  logic signed [sic_pkg::IN_BITS-1:0]  seg2_end_y,
	output logic                                done,
	output logic [1:0]                          relation_code
);
	import sic_pkg::*;

	localparam int PW      = 2 * (COORD_BITS + 1);
	localparam int LATENCY = 5;

	logic                         req_vld;
	logic                         vld_s1, vld_s2, vld_s4, vld_s5;
	sic_eq_t                      eq_s1, eq_s2;
	logic signed [COORD_BITS:0]   dx_s1 [NUM_DIFF];
	logic signed [COORD_BITS:0]   dy_s1 [NUM_DIFF];
	logic signed [PW-1:0]         pca_s2 [NUM_CROSS];
	logic signed [PW-1:0]         pcb_s2 [NUM_CROSS];
	logic signed [PW-1:0]         pda_s2 [NUM_DOT];
	logic signed [PW-1:0]         pdb_s2 [NUM_DOT];
	sic_flags_t                   flags_s4;
	logic [NUM_PROJ-1:0]          on_seg;
	logic                         max_neg, min_gt, max_zero, min_eq;
	logic                         cross12, cross34;
	sic_rel_t                     code_d;
	sic_rel_t                     code_s5;

	// Fully pipelined: every request is taken
	assign busy    = 1'b0;
	assign req_vld = start && !busy;

	sic_delta #(.COORD_BITS(COORD_BITS)) u_delta (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_vld       (req_vld),
		.seg1_start_x (seg1_start_x),
		.seg1_start_y (seg1_start_y),
		.seg1_end_x   (seg1_end_x),
		.seg1_end_y   (seg1_end_y),
		.seg2_start_x (seg2_start_x),
		.seg2_start_y (seg2_start_y),
		.seg2_end_x   (seg2_end_x),
		.seg2_end_y   (seg2_end_y),
		.vld_s1       (vld_s1),
		.eq_s1        (eq_s1),
		.dx_s1        (dx_s1),
		.dy_s1        (dy_s1)
	);

	sic_product #(.COORD_BITS(COORD_BITS)) u_product (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s1 (vld_s1),
		.eq_s1  (eq_s1),
		.dx_s1  (dx_s1),
		.dy_s1  (dy_s1),
		.vld_s2 (vld_s2),
		.eq_s2  (eq_s2),
		.pca_s2 (pca_s2),
		.pcb_s2 (pcb_s2),
		.pda_s2 (pda_s2),
		.pdb_s2 (pdb_s2)
	);

	sic_combine #(.COORD_BITS(COORD_BITS)) u_combine (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld_s2   (vld_s2),
		.eq_s2    (eq_s2),
		.pca_s2   (pca_s2),
		.pcb_s2   (pcb_s2),
		.pda_s2   (pda_s2),
		.pdb_s2   (pdb_s2),
		.vld_s4   (vld_s4),
		.flags_s4 (flags_s4)
	);

	// Endpoint lies on the other segment: collinear and projection within [0, squared length]
	always_comb begin
		for (int p = 0; p < NUM_PROJ; p++) begin
			on_seg[p] = flags_s4.or_zero[p] && !flags_s4.dt_neg[p] && !flags_s4.dt_gt[p];
		end
	end

	// Collinear case: order the two projections onto seg1
	assign max_neg  = flags_s4.dt_neg[PJ_S2] && flags_s4.dt_neg[PJ_E2];
	assign min_gt   = flags_s4.dt_gt[PJ_S2] && flags_s4.dt_gt[PJ_E2];
	assign max_zero = flags_s4.d1_gt_d2 ? flags_s4.dt_zero[PJ_S2] : flags_s4.dt_zero[PJ_E2];
	assign min_eq   = flags_s4.d1_gt_d2 ? flags_s4.dt_eq[PJ_E2] : flags_s4.dt_eq[PJ_S2];

	// Strict straddle on each line
	assign cross12 = !flags_s4.or_zero[PJ_S2] && !flags_s4.or_zero[PJ_E2]
		&& (flags_s4.or_neg[PJ_S2] != flags_s4.or_neg[PJ_E2]);
	assign cross34 = !flags_s4.or_zero[PJ_S1] && !flags_s4.or_zero[PJ_E1]
		&& (flags_s4.or_neg[PJ_S1] != flags_s4.or_neg[PJ_E1]);

	// Final decision
	always_comb begin
		code_d = REL_DISJOINT;
		if (flags_s4.eq.pt1) begin
			if (flags_s4.eq.pt2) begin
				code_d = flags_s4.eq.pp_eq ? REL_TOUCH : REL_DISJOINT;
			end else begin
				code_d = on_seg[PJ_S1] ? REL_TOUCH : REL_DISJOINT;
			end
		end else if (flags_s4.eq.pt2) begin
			code_d = on_seg[PJ_S2] ? REL_TOUCH : REL_DISJOINT;
		end else if (flags_s4.or_zero[PJ_S2] && flags_s4.or_zero[PJ_E2]) begin
			if (max_neg || min_gt) begin
				code_d = REL_DISJOINT;
			end else if (max_zero || min_eq) begin
				code_d = REL_TOUCH;
			end else begin
				code_d = REL_OVERLAP;
			end
		end else if (cross12 && cross34) begin
			code_d = REL_CROSS;
		end else if (on_seg != '0) begin
			code_d = REL_TOUCH;
		end
	end

	// Stage 5: result register and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s4) begin
			code_s5 <= code_d;
		end
	end

	assign done          = vld_s5;
	assign relation_code = code_s5;

	// Every request yields its result after the pipeline depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("request without result after pipeline depth");

	// No result without a request
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching request");

	// A proper crossing needs two real segments and no zero orientation
	a_cross_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done && relation_code == REL_CROSS |->
			$past(flags_s4.or_zero == '0 && !flags_s4.eq.pt1 && !flags_s4.eq.pt2))
		else $error("crossing reported with degenerate orientation");

	// Overlap only for collinear segments
	a_overlap_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done && relation_code == REL_OVERLAP |->
			$past(flags_s4.or_zero[PJ_S2] && flags_s4.or_zero[PJ_E2]))
		else $error("overlap reported for non-collinear segments");

endmodule
